// File: design/wav_riff_header_parser_assert.svh
// Assertion macros used by the parser control module (wrp_ctrl).
`ifndef WAV_RIFF_HEADER_PARSER_ASSERT_SVH
`define WAV_RIFF_HEADER_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

`define WRP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define WRP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`define WRP_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define WRP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WRP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`define WRP_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// File: design/wrp_pkg.sv
`default_nettype none
package wrp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int FMT_BASE_LEN = 16;
    localparam int FMT_BITS_AT  = 14;

    localparam int FRAME_W   = 35;
    localparam int DIV_STEPS = 35;
    localparam int DIV_CNT_W = 6;
    localparam int TDATA_W   = 112;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_RIFF   = 3'd1;
    localparam logic [2:0] ST_NO_WAVE   = 3'd2;
    localparam logic [2:0] ST_NO_FMT    = 3'd3;
    localparam logic [2:0] ST_NO_DATA   = 3'd4;
    localparam logic [2:0] ST_SHORT_FMT = 3'd5;
    localparam logic [2:0] ST_ZERO_DIV  = 3'd6;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_HDR  = 3'd1;
    localparam logic [2:0] OP_WAVE = 3'd2;
    localparam logic [2:0] OP_BODY = 3'd3;
    localparam logic [2:0] OP_SKIP = 3'd4;
    localparam logic [2:0] OP_PAY  = 3'd5;

    typedef struct packed {
        logic       acc;
        logic       clear;
        logic [2:0] op;
        logic       ld_skip;
        logic       ld_pay;
        logic       div_start;
        logic       st_we;
        logic [2:0] st_code;
    } t_cmd;

    typedef struct packed {
        logic hdr_last;
        logic wave_last;
        logic body_last;
        logic tag_riff;
        logic tag_wave;
        logic tag_fmt;
        logic tag_data;
        logic size_small;
        logic size_zero;
        logic size_is16;
        logic skip_one;
        logic pay_one;
        logic div_zero;
        logic div_done;
    } t_flags;

endpackage
`default_nettype wire

// File: design/wrp_div.sv
`default_nettype none
module wrp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wrp_pkg::FRAME_W-1:0] i_dividend,
    input  wire logic [31:0]                 i_divisor,
    output logic                             o_done,
    output logic [wrp_pkg::FRAME_W-1:0]      o_quot
);
    import wrp_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [31:0]          r_rem;
    logic [31:0]          r_dsr;
    logic [FRAME_W-1:0]   r_quo;

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;
    logic [31:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[FRAME_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});
        n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[FRAME_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// File: design/wrp_dp.sv
`default_nettype none
module wrp_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [7:0]                  i_byte,
    input  wire wrp_pkg::t_cmd               i_cmd,
    output wrp_pkg::t_flags                  o_flags,
    output logic [7:0]                       o_pbyte,
    output logic [15:0]                      o_channels,
    output logic [31:0]                      o_rate,
    output logic [15:0]                      o_bits,
    output logic [wrp_pkg::FRAME_W-1:0]      o_frames,
    output logic [2:0]                       o_status
);
    import wrp_pkg::*;

    logic [3:0]         r_idx;
    logic [31:0]        r_tag;
    logic [31:0]        r_size;
    logic [31:0]        r_skip;
    logic [31:0]        r_pay;
    logic [15:0]        r_ch;
    logic [31:0]        r_rate;
    logic [15:0]        r_bits;
    logic [FRAME_W-1:0] r_frames;
    logic [2:0]         r_status;
    logic [31:0]        r_prod;
    logic [7:0]         r_pbyte;

    logic [3:0]         e_idx;
    logic [31:0]        e_tag;
    logic [31:0]        e_size;
    logic [31:0]        e_skip;
    logic [31:0]        e_pay;
    logic [15:0]        e_ch;
    logic [31:0]        e_rate;
    logic [15:0]        e_bits;
    logic [2:0]         w_hi;
    logic [31:0]        n_tag;
    logic [31:0]        n_size;
    logic               w_div_done;
    logic [FRAME_W-1:0] w_quot;

    always_comb begin
        e_idx  = i_cmd.clear ? '0 : r_idx;
        e_tag  = i_cmd.clear ? '0 : r_tag;
        e_size = i_cmd.clear ? '0 : r_size;
        e_skip = i_cmd.clear ? '0 : r_skip;
        e_pay  = i_cmd.clear ? '0 : r_pay;
        e_ch   = i_cmd.clear ? '0 : r_ch;
        e_rate = i_cmd.clear ? '0 : r_rate;
        e_bits = i_cmd.clear ? '0 : r_bits;
        w_hi   = e_idx[2:0];
        n_tag  = {e_tag[23:0], i_byte};
        n_size = (w_hi == 3'd0) ? '0 : e_size;
        case (w_hi)
            3'd4: n_size[7:0]   = i_byte;
            3'd5: n_size[15:8]  = i_byte;
            3'd6: n_size[23:16] = i_byte;
            3'd7: n_size[31:24] = i_byte;
            default: ;
        endcase
    end

    always_comb begin
        o_flags.hdr_last   = (w_hi == 3'd7);
        o_flags.wave_last  = (e_idx == 4'd3);
        o_flags.body_last  = (e_idx == 4'(FMT_BASE_LEN - 1));
        o_flags.tag_riff   = (e_tag == TAG_RIFF);
        o_flags.tag_wave   = (n_tag == TAG_WAVE);
        o_flags.tag_fmt    = (e_tag == TAG_FMT);
        o_flags.tag_data   = (e_tag == TAG_DATA);
        o_flags.size_small = (n_size < 32'(FMT_BASE_LEN));
        o_flags.size_zero  = (n_size == '0);
        o_flags.size_is16  = (e_size == 32'(FMT_BASE_LEN));
        o_flags.skip_one   = (e_skip == 32'd1);
        o_flags.pay_one    = (e_pay == 32'd1);
        o_flags.div_zero   = (e_ch == '0) || (e_bits == '0);
        o_flags.div_done   = w_div_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_tag    <= '0;
            r_size   <= '0;
            r_skip   <= '0;
            r_pay    <= '0;
            r_ch     <= '0;
            r_rate   <= '0;
            r_bits   <= '0;
            r_frames <= '0;
            r_status <= ST_OK;
        end else if (i_cmd.acc) begin
            r_idx  <= e_idx;
            r_tag  <= e_tag;
            r_size <= e_size;
            r_skip <= e_skip;
            r_pay  <= e_pay;
            r_ch   <= e_ch;
            r_rate <= e_rate;
            r_bits <= e_bits;
            if (i_cmd.clear) begin
                r_frames <= '0;
            end
            case (i_cmd.op)
                OP_HDR: begin
                    if (w_hi < 3'd4) begin
                        r_tag <= n_tag;
                    end
                    r_size <= n_size;
                    r_idx  <= o_flags.hdr_last ? 4'd0 : 4'(w_hi) + 4'd1;
                end
                OP_WAVE: begin
                    r_tag <= n_tag;
                    r_idx <= o_flags.wave_last ? 4'd0 : e_idx + 4'd1;
                end
                OP_BODY: begin
                    case (e_idx)
                        4'd2: r_ch[7:0]       <= i_byte;
                        4'd3: r_ch[15:8]      <= i_byte;
                        4'd4: r_rate[7:0]     <= i_byte;
                        4'd5: r_rate[15:8]    <= i_byte;
                        4'd6: r_rate[23:16]   <= i_byte;
                        4'd7: r_rate[31:24]   <= i_byte;
                        4'(FMT_BITS_AT):     r_bits[7:0]  <= i_byte;
                        4'(FMT_BITS_AT + 1): r_bits[15:8] <= i_byte;
                        default: ;
                    endcase
                    if (o_flags.body_last) begin
                        r_idx  <= '0;
                        r_skip <= e_size - 32'(FMT_BASE_LEN);
                    end else begin
                        r_idx <= e_idx + 4'd1;
                    end
                end
                OP_SKIP: r_skip <= e_skip - 32'd1;
                OP_PAY:  r_pay  <= e_pay - 32'd1;
                default: ;
            endcase
            if (i_cmd.ld_skip) begin
                r_skip <= n_size;
            end
            if (i_cmd.ld_pay) begin
                r_pay <= n_size;
            end
            if (i_cmd.st_we) begin
                r_status <= i_cmd.st_code;
            end else if (i_cmd.clear) begin
                r_status <= ST_OK;
            end
        end else if (w_div_done) begin
            r_frames <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 32'(r_ch) * 32'(r_bits);
        if (i_cmd.acc) begin
            r_pbyte <= (i_cmd.op == OP_PAY) ? i_byte : 8'd0;
        end
    end

    wrp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.acc && i_cmd.div_start),
        .i_dividend ({n_size, 3'b000}),
        .i_divisor  (r_prod),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_pbyte    = r_pbyte;
    assign o_channels = r_ch;
    assign o_rate     = r_rate;
    assign o_bits     = r_bits;
    assign o_frames   = r_frames;
    assign o_status   = r_status;

endmodule
`default_nettype wire

// File: design/wrp_ctrl.sv
`default_nettype none
`include "wav_riff_header_parser_assert.svh"
module wrp_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_first,
    input  wire logic            i_eos,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_pvalid,
    output logic                 o_plast,
    output logic                 o_hready,
    output wrp_pkg::t_cmd        o_cmd,
    input  wire wrp_pkg::t_flags i_flags
);
    import wrp_pkg::*;

    localparam logic [3:0] PH_RIFF      = 4'd0;
    localparam logic [3:0] PH_WAVE      = 4'd1;
    localparam logic [3:0] PH_FMT_HDR   = 4'd2;
    localparam logic [3:0] PH_FMT_SKIP  = 4'd3;
    localparam logic [3:0] PH_FMT_BODY  = 4'd4;
    localparam logic [3:0] PH_FMT_TAIL  = 4'd5;
    localparam logic [3:0] PH_DATA_HDR  = 4'd6;
    localparam logic [3:0] PH_DATA_SKIP = 4'd7;
    localparam logic [3:0] PH_PAYLOAD   = 4'd8;
    localparam logic [3:0] PH_DONE      = 4'd9;
    localparam logic [3:0] PH_ERROR     = 4'd10;

    logic [3:0] r_phase;
    logic       r_busy;
    logic       r_oval;
    logic       r_pvalid;
    logic       r_plast;
    logic       r_hready;

    logic [3:0] e_phase;
    logic [3:0] n_phase;
    logic       n_pvalid;
    logic       n_plast;
    logic       w_acc;

    assign o_in_ready = !r_busy && (!r_oval || i_out_ready);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        e_phase         = i_first ? PH_RIFF : r_phase;
        n_phase         = e_phase;
        n_pvalid        = 1'b0;
        n_plast         = 1'b0;
        o_cmd           = '0;
        o_cmd.acc       = w_acc;
        o_cmd.clear     = w_acc && i_first;
        o_cmd.op        = OP_NONE;
        o_cmd.st_code   = ST_OK;
        case (e_phase)
            PH_RIFF: begin
                o_cmd.op = OP_HDR;
                if (i_flags.hdr_last) begin
                    if (i_flags.tag_riff) begin
                        n_phase = PH_WAVE;
                    end else begin
                        n_phase       = PH_ERROR;
                        o_cmd.st_we   = 1'b1;
                        o_cmd.st_code = ST_NO_RIFF;
                    end
                end
            end
            PH_WAVE: begin
                o_cmd.op = OP_WAVE;
                if (i_flags.wave_last) begin
                    if (i_flags.tag_wave) begin
                        n_phase = PH_FMT_HDR;
                    end else begin
                        n_phase       = PH_ERROR;
                        o_cmd.st_we   = 1'b1;
                        o_cmd.st_code = ST_NO_WAVE;
                    end
                end
            end
            PH_FMT_HDR, PH_DATA_HDR: begin
                o_cmd.op = OP_HDR;
                if (i_flags.hdr_last) begin
                    if (e_phase == PH_FMT_HDR && i_flags.tag_fmt) begin
                        if (i_flags.size_small) begin
                            n_phase       = PH_ERROR;
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_SHORT_FMT;
                        end else begin
                            n_phase = PH_FMT_BODY;
                        end
                    end else if (e_phase == PH_DATA_HDR && i_flags.tag_data) begin
                        if (i_flags.div_zero) begin
                            n_phase       = PH_ERROR;
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_ZERO_DIV;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.ld_pay    = 1'b1;
                            n_phase = i_flags.size_zero ? PH_DONE : PH_PAYLOAD;
                        end
                    end else if (!i_flags.size_zero) begin
                        o_cmd.ld_skip = 1'b1;
                        n_phase = (e_phase == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
                    end
                end
            end
            PH_FMT_SKIP, PH_FMT_TAIL, PH_DATA_SKIP: begin
                o_cmd.op = OP_SKIP;
                if (i_flags.skip_one) begin
                    n_phase = (e_phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
                end
            end
            PH_FMT_BODY: begin
                o_cmd.op = OP_BODY;
                if (i_flags.body_last) begin
                    n_phase = i_flags.size_is16 ? PH_DATA_HDR : PH_FMT_TAIL;
                end
            end
            PH_PAYLOAD: begin
                o_cmd.op = OP_PAY;
                n_pvalid = 1'b1;
                if (i_flags.pay_one) begin
                    n_plast = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase

        if (i_eos) begin
            case (n_phase)
                PH_RIFF: begin
                    n_phase       = PH_ERROR;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_NO_RIFF;
                end
                PH_WAVE: begin
                    n_phase       = PH_ERROR;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_NO_WAVE;
                end
                PH_FMT_HDR, PH_FMT_SKIP: begin
                    n_phase       = PH_ERROR;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_NO_FMT;
                end
                PH_FMT_BODY: begin
                    n_phase       = PH_ERROR;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_SHORT_FMT;
                end
                PH_FMT_TAIL, PH_DATA_HDR, PH_DATA_SKIP: begin
                    n_phase       = PH_ERROR;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_NO_DATA;
                end
                PH_PAYLOAD: begin
                    n_plast = n_plast || n_pvalid;
                    n_phase = PH_DONE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RIFF;
            r_busy   <= 1'b0;
            r_oval   <= 1'b0;
            r_pvalid <= 1'b0;
            r_plast  <= 1'b0;
            r_hready <= 1'b0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            if (o_cmd.div_start) begin
                r_busy <= 1'b1;
                r_oval <= 1'b0;
            end else begin
                r_oval   <= 1'b1;
                r_pvalid <= n_pvalid;
                r_plast  <= n_plast;
                r_hready <= 1'b0;
            end
        end else if (i_flags.div_done) begin
            r_busy   <= 1'b0;
            r_oval   <= 1'b1;
            r_pvalid <= 1'b0;
            r_plast  <= 1'b0;
            r_hready <= 1'b1;
        end else if (i_out_ready) begin
            r_oval <= 1'b0;
        end
    end

    assign o_out_valid = r_oval;
    assign o_pvalid    = r_pvalid;
    assign o_plast     = r_plast;
    assign o_hready    = r_hready;

    `WRP_ASSERT_NEVER(a_busy_without_out, i_clk, i_rst_n, r_busy && r_oval)
    `WRP_ASSERT_IMP(a_done_only_busy, i_clk, i_rst_n, i_flags.div_done, r_busy)
    `WRP_ASSERT_NXT(a_start_holds, i_clk, i_rst_n, w_acc && o_cmd.div_start, r_busy && !r_oval)
    `WRP_ASSERT_IMP(a_last_is_payload, i_clk, i_rst_n, r_oval && r_plast, r_pvalid)

endmodule
`default_nettype wire

// File: design/wav_riff_header_parser.sv
// RIFF/WAVE header parser with payload pass-through.
// Input stream s_axis: one file byte per item in tdata, tuser = first byte of a
// file (restarts parsing), tlast = final byte available from the file.
// Output stream m_axis: exactly one item per input item, in order. tdata holds
// the payload byte, the held fmt values, the frame count and the status code;
// tuser flags a payload byte and the end of the data chunk header; tlast marks
// the final payload byte.
// Each result is registered and appears in the cycle after its byte is accepted, so one byte
// per cycle is sustained while the receiver keeps m_axis_tready high and no divide is running.
// The byte that completes the data chunk header starts a bit-serial divider
// for the frame count: its result appears once the divider finishes, and
// s_axis_tready stays low meanwhile. This happens at most once per file.
// When the receiver stalls, the result is held in the output register and
// s_axis_tready drops until it is taken; a new byte is accepted in the same
// cycle as the waiting result leaves.
// Reset (synchronous, active low) clears the parser, the held values and the
// output valid and flag registers; no result is pending after reset.
`default_nettype none
module wav_riff_header_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // in_byte
    input  wire logic                        s_axis_tuser,  // first_byte
    input  wire logic                        s_axis_tlast,  // end_of_stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // payload_byte, channel_count, sample_rate, bit_depth, frame_count,
    // status, zero fill
    output logic [wrp_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // payload_valid, header_ready
    output logic                             m_axis_tlast   // payload_last
);
    import wrp_pkg::*;

    t_cmd               w_cmd;
    t_flags             w_flags;
    logic               w_pvalid;
    logic               w_plast;
    logic               w_hready;
    logic [7:0]         w_pbyte;
    logic [15:0]        w_channels;
    logic [31:0]        w_rate;
    logic [15:0]        w_bits;
    logic [FRAME_W-1:0] w_frames;
    logic [2:0]         w_status;

    wrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_first     (s_axis_tuser),
        .i_eos       (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_pvalid    (w_pvalid),
        .o_plast     (w_plast),
        .o_hready    (w_hready),
        .o_cmd       (w_cmd),
        .i_flags     (w_flags)
    );

    wrp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_flags    (w_flags),
        .o_pbyte    (w_pbyte),
        .o_channels (w_channels),
        .o_rate     (w_rate),
        .o_bits     (w_bits),
        .o_frames   (w_frames),
        .o_status   (w_status)
    );

    assign m_axis_tdata = {2'b00, w_status, w_frames, w_bits, w_rate, w_channels, w_pbyte};
    assign m_axis_tuser = {w_hready, w_pvalid};
    assign m_axis_tlast = w_plast;

endmodule
`default_nettype wire

// File: sim/wav_riff_header_parser_tb.sv
`timescale 1ns / 100ps
module wav_riff_header_parser_tb;
    import wrp_pkg::*;

    localparam int TOTAL_ITEMS = 1850;
    localparam int TAIL_CYCLES = 48;
    localparam int LIMIT_NS    = 2_000_000;

    typedef enum logic [3:0] {
        WAIT_RIFF, WAIT_WAVE, FIND_FMT, SKIP_TO_FMT, READ_FMT, FMT_REST,
        FIND_DATA, SKIP_TO_DATA, PASS_PAYLOAD, FILE_DONE, FILE_BAD
    } t_parser_phase;

    typedef struct {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        pay_last;
        logic        hdr_done;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] depth;
        logic [34:0] frames;
        logic [2:0]  status;
    } t_wav_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'h00;  // in_byte
    logic                 s_axis_tuser  = 1'b0;   // first_byte
    logic                 s_axis_tlast  = 1'b0;   // end_of_stream
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // payload_byte, channel_count, sample_rate, bit_depth, frame_count, status, zero fill
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]           m_axis_tuser;           // payload_valid, header_ready
    logic                 m_axis_tlast;           // payload_last

    t_wav_result          expected_results[$];
    logic [7:0]           file_bytes[$];
    int                   mismatch_count = 0;
    int                   sent_items     = 0;
    int                   burst_left     = 0;
    logic [15:0]          rx_pattern     = 16'hFFFF;
    int                   rx_age         = 0;

    t_parser_phase        phase;
    logic [4:0]           hdr_idx;
    logic [31:0]          tag_sr;
    logic [31:0]          chunk_len;
    logic [31:0]          skip_cnt;
    logic [31:0]          pay_cnt;
    logic [15:0]          fmt_channels;
    logic [31:0]          fmt_rate;
    logic [15:0]          fmt_depth;
    logic [34:0]          frames;
    logic [2:0]           stat;

    wav_riff_header_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic void clear_parser();
        phase        = WAIT_RIFF;
        hdr_idx      = '0;
        tag_sr       = '0;
        chunk_len    = '0;
        skip_cnt     = '0;
        pay_cnt      = '0;
        fmt_channels = '0;
        fmt_rate     = '0;
        fmt_depth    = '0;
        frames       = '0;
        stat         = ST_OK;
    endfunction

    function automatic void abort_file(input logic [2:0] code);
        stat  = code;
        phase = FILE_BAD;
    endfunction

    // shift in one byte of an 8-byte chunk header; 1 once the size is complete
    function automatic logic chunk_hdr_byte(input logic [7:0] b);
        logic [2:0] pos;
        pos = hdr_idx[2:0];
        if (pos == 3'd0) chunk_len = '0;
        if (pos < 3'd4) tag_sr = {tag_sr[23:0], b};
        else chunk_len[8*(int'(pos)-4) +: 8] = b;
        if (pos == 3'd7) begin
            hdr_idx = '0;
            return 1'b1;
        end
        hdr_idx = 5'(pos) + 5'd1;
        return 1'b0;
    endfunction

    task automatic predict_item(input logic [7:0] b, input logic first, input logic eos);
        t_wav_result r;
        logic [63:0] divisor;
        logic [3:0]  k;
        logic        in_fmt;
        r = '{default: '0};
        if (first) clear_parser();
        case (phase)
            WAIT_RIFF: begin
                if (chunk_hdr_byte(b)) begin
                    if (tag_sr != TAG_RIFF) abort_file(ST_NO_RIFF);
                    else phase = WAIT_WAVE;
                end
            end
            WAIT_WAVE: begin
                tag_sr  = {tag_sr[23:0], b};
                hdr_idx = hdr_idx + 5'd1;
                if (hdr_idx >= 5'd4) begin
                    hdr_idx = '0;
                    if (tag_sr != TAG_WAVE) abort_file(ST_NO_WAVE);
                    else phase = FIND_FMT;
                end
            end
            FIND_FMT, FIND_DATA: begin
                if (chunk_hdr_byte(b)) begin
                    in_fmt = (phase == FIND_FMT);
                    if (in_fmt && tag_sr == TAG_FMT) begin
                        if (chunk_len < FMT_BASE_LEN) abort_file(ST_SHORT_FMT);
                        else phase = READ_FMT;
                    end else if (!in_fmt && tag_sr == TAG_DATA) begin
                        divisor = 64'(fmt_channels) * 64'(fmt_depth);
                        if (divisor == 64'd0) begin
                            abort_file(ST_ZERO_DIV);
                        end else begin
                            frames     = 35'((64'(chunk_len) << 3) / divisor);
                            r.hdr_done = 1'b1;
                            pay_cnt    = chunk_len;
                            phase      = (pay_cnt != 0) ? PASS_PAYLOAD : FILE_DONE;
                        end
                    end else if (chunk_len != 0) begin
                        skip_cnt = chunk_len;
                        phase    = in_fmt ? SKIP_TO_FMT : SKIP_TO_DATA;
                    end
                end
            end
            SKIP_TO_FMT, FMT_REST, SKIP_TO_DATA: begin
                skip_cnt = skip_cnt - 32'd1;
                if (skip_cnt == 0) phase = (phase == SKIP_TO_FMT) ? FIND_FMT : FIND_DATA;
            end
            READ_FMT: begin
                k = hdr_idx[3:0];
                if (k == 4'd2) fmt_channels[7:0] = b;
                if (k == 4'd3) fmt_channels[15:8] = b;
                if (k >= 4'd4 && k <= 4'd7) fmt_rate[8*(int'(k)-4) +: 8] = b;
                if (k == FMT_BITS_AT) fmt_depth[7:0] = b;
                if (k == FMT_BITS_AT + 1) fmt_depth[15:8] = b;
                if (k == FMT_BASE_LEN - 1) begin
                    hdr_idx  = '0;
                    skip_cnt = chunk_len - FMT_BASE_LEN;
                    phase    = (skip_cnt != 0) ? FMT_REST : FIND_DATA;
                end else begin
                    hdr_idx = 5'(k) + 5'd1;
                end
            end
            PASS_PAYLOAD: begin
                r.pay_valid = 1'b1;
                r.pay_byte  = b;
                pay_cnt     = pay_cnt - 32'd1;
                if (pay_cnt == 0) begin
                    r.pay_last = 1'b1;
                    phase      = FILE_DONE;
                end
            end
            default: ;
        endcase
        if (eos) begin
            case (phase)
                WAIT_RIFF:                         abort_file(ST_NO_RIFF);
                WAIT_WAVE:                         abort_file(ST_NO_WAVE);
                FIND_FMT, SKIP_TO_FMT:             abort_file(ST_NO_FMT);
                READ_FMT:                          abort_file(ST_SHORT_FMT);
                FMT_REST, FIND_DATA, SKIP_TO_DATA: abort_file(ST_NO_DATA);
                PASS_PAYLOAD: begin
                    if (r.pay_valid) r.pay_last = 1'b1;
                    phase = FILE_DONE;
                end
                default: ;
            endcase
        end
        r.channels = fmt_channels;
        r.rate     = fmt_rate;
        r.depth    = fmt_depth;
        r.frames   = frames;
        r.status   = stat;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_wav_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("item with nothing expected", 64'(m_axis_tdata[7:0]), 64'd0);
            end else begin
                want = expected_results.pop_front();
                check_field("payload_valid", 64'(m_axis_tuser[0]), 64'(want.pay_valid));
                check_field("header_ready", 64'(m_axis_tuser[1]), 64'(want.hdr_done));
                check_field("payload_last", 64'(m_axis_tlast), 64'(want.pay_last));
                check_field("payload_byte", 64'(m_axis_tdata[7:0]), 64'(want.pay_byte));
                check_field("channel_count", 64'(m_axis_tdata[23:8]), 64'(want.channels));
                check_field("sample_rate", 64'(m_axis_tdata[55:24]), 64'(want.rate));
                check_field("bit_depth", 64'(m_axis_tdata[71:56]), 64'(want.depth));
                check_field("frame_count", 64'(m_axis_tdata[106:72]), 64'(want.frames));
                check_field("status", 64'(m_axis_tdata[109:107]), 64'(want.status));
            end
        end
    end

    // rotate a stall pattern, reloading it now and then
    always @(posedge i_clk) begin
        if (rx_age == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    rx_pattern <= 16'hFFFF;
                2:       rx_pattern <= 16'($urandom) | 16'h0001;
                3:       rx_pattern <= 16'h0001;
                default: rx_pattern <= 16'hF0F0;
            endcase
            rx_age <= $urandom_range(16, 200);
        end else begin
            rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
            rx_age     <= rx_age - 1;
        end
        m_axis_tready <= rx_pattern[0];
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic eos);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(b, first, eos);
        sent_items++;
        burst_left--;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic put_tag(input logic [31:0] t);
        file_bytes.push_back(t[31:24]);
        file_bytes.push_back(t[23:16]);
        file_bytes.push_back(t[15:8]);
        file_bytes.push_back(t[7:0]);
    endtask

    task automatic put_le16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endtask

    task automatic put_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_chunk_hdr(input logic [31:0] tag, input logic [31:0] len);
        put_tag(tag);
        put_le32(len);
    endtask

    task automatic put_riff();
        put_chunk_hdr(TAG_RIFF, $urandom);
        put_tag(TAG_WAVE);
    endtask

    task automatic put_fmt(input logic [31:0] len, input logic [15:0] ch,
                           input logic [31:0] rate, input logic [15:0] depth);
        put_chunk_hdr(TAG_FMT, len);
        if (len >= FMT_BASE_LEN) begin
            put_le16(16'd1);
            put_le16(ch);
            put_le32(rate);
            put_le32($urandom);
            put_le16(16'($urandom));
            put_le16(depth);
            put_random(int'(len) - FMT_BASE_LEN);
        end
    endtask

    task automatic put_filler_chunk(input logic [31:0] alt_tag);
        int len;
        len = $urandom_range(0, 9);
        put_chunk_hdr(($urandom_range(0, 3) == 0) ? alt_tag : $urandom, len);
        put_random(len);
    endtask

    task automatic play_file(input int eos_at);
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0, i == eos_at);
        file_bytes.delete();
    endtask

    task automatic test_plain_files();
        // restart in the middle of the payload
        put_riff();
        put_fmt(16, 2, 44100, 16);
        put_chunk_hdr(TAG_DATA, 20);
        put_random(6);
        play_file(-1);
        put_riff();
        put_fmt(16, 2, 44100, 16);
        put_chunk_hdr(TAG_DATA, 8);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        put_random(9);
        play_file(-1);
        wait_for_results();
    endtask

    task automatic test_bad_tags();
        put_chunk_hdr(TAG_RIFF ^ 32'h1, 36);
        put_random(4);
        play_file(-1);
        put_chunk_hdr(TAG_RIFF, 36);
        put_tag(TAG_WAVE ^ 32'h0100_0000);
        put_fmt(16, 1, 8000, 8);
        play_file(-1);
        wait_for_results();
    endtask

    task automatic test_fmt_errors();
        put_riff();
        put_fmt(15, 1, 8000, 8);
        put_random(4);
        play_file(-1);
        put_riff();
        put_fmt(16, 0, 8000, 16);
        put_chunk_hdr(TAG_DATA, 4);
        put_random(4);
        play_file(-1);
        put_riff();
        put_fmt(16, 3, 8000, 0);
        put_chunk_hdr(TAG_DATA, 4);
        put_random(4);
        play_file(-1);
        wait_for_results();
    endtask

    task automatic test_early_end();
        put_tag(TAG_RIFF);
        play_file(2);
        put_chunk_hdr(TAG_RIFF, 0);
        put_tag(TAG_WAVE);
        play_file(9);
        // end inside a skipped chunk, then inside the fmt body, then in its tail
        put_riff();
        put_chunk_hdr(32'h4C49_5354, 6);
        put_random(6);
        play_file(22);
        put_riff();
        put_fmt(16, 2, 22050, 8);
        play_file(25);
        put_riff();
        put_fmt(18, 2, 22050, 8);
        put_chunk_hdr(TAG_DATA, 4);
        play_file(36);
        wait_for_results();
    endtask

    task automatic test_extremes();
        // data tag ahead of fmt, odd and empty chunks, fmt tag after fmt
        put_riff();
        put_chunk_hdr(TAG_DATA, 2);
        put_random(2);
        put_chunk_hdr(32'h4C49_5354, 3);
        put_random(3);
        put_chunk_hdr(32'h0, 0);
        put_fmt(20, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_chunk_hdr(TAG_FMT, 1);
        put_random(1);
        put_chunk_hdr(TAG_DATA, 32'hFFFF_FFFF);
        put_random(3);
        play_file(file_bytes.size() - 1);
        put_riff();
        put_fmt(16, 1, 0, 1);
        put_chunk_hdr(TAG_DATA, 32'hFFFF_FFFF);
        put_random(4);
        play_file(file_bytes.size() - 1);
        put_riff();
        put_fmt(16, 2, 48000, 24);
        put_chunk_hdr(TAG_DATA, 0);
        put_random(3);
        play_file(-1);
        wait_for_results();
    endtask

    task automatic test_random_files();
        logic [15:0] ch;
        logic [15:0] depth;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        int          n_pay;
        int          eos_at;
        int          pick;
        int          idx;
        while (sent_items < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
                continue;
            end
            pick = $urandom_range(0, 19);
            ch = (pick == 0) ? 16'd0 : (pick < 3) ? 16'($urandom) : 16'($urandom_range(1, 8));
            pick = $urandom_range(0, 19);
            depth = (pick == 0) ? 16'd0 : (pick < 3) ? 16'($urandom)
                                                   : 16'(8 * $urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) fmt_len = $urandom_range(0, 15);
            else if ($urandom_range(0, 3) == 0) fmt_len = 16 + $urandom_range(1, 8);
            else fmt_len = 16;
            pick = $urandom_range(0, 9);
            data_len = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom : $urandom_range(1, 40);
            n_pay = (data_len > 48) ? $urandom_range(0, 12) : int'(data_len);

            put_riff();
            repeat ($urandom_range(0, 2)) put_filler_chunk(TAG_DATA);
            put_fmt(fmt_len, ch, $urandom, depth);
            if (fmt_len >= FMT_BASE_LEN)
                repeat ($urandom_range(0, 2)) put_filler_chunk(TAG_FMT);
            put_chunk_hdr(TAG_DATA, data_len);
            put_random(n_pay);

            pick = $urandom_range(0, 99);
            if (pick < 12) eos_at = $urandom_range(0, file_bytes.size() - 1);
            else if (pick < 22) eos_at = -1;
            else eos_at = file_bytes.size() - 1;
            if ($urandom_range(0, 9) == 0) begin
                idx = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 7) == 0) put_random($urandom_range(1, 6));
            play_file(eos_at);
            if ($urandom_range(0, 19) == 0) wait_for_results();
        end
    endtask

    initial begin
        clear_parser();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_files();
        test_bad_tags();
        test_fmt_errors();
        test_early_end();
        test_extremes();
        test_random_files();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never produced", 64'(expected_results.size()), 64'd0);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
